// ===== src/sti_pkg.sv =====
// Shared types and constants for the sorted record table.
// No dependencies; used by the table top level and its checker.
package sti_pkg;

    localparam int STI_DEPTH     = 16;
    localparam int STI_KEY_CHARS = 8;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_RANGE = 2'd2
    } t_status;

    typedef struct packed {
        logic        [63:0] key;
        logic        [63:0] publisher;
        logic signed [31:0] price;
    } t_record;

endpackage

// ===== src/sti_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module sti_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rd_data <= r_mem[i_raddr];
    end

    assign o_rdata = r_rd_data;

endmodule

// ===== src/sorted_table_insert.sv =====
// Sorted record table: a bounded table of records kept in ascending key order. An insert
// walks the table from the top entry down, one entry at a time, through a single compare
// unit and one record memory; each stored entry with a strictly greater key moves up one
// place, and the new record lands just above the first entry that is not greater, so equal
// keys keep arrival order. Each entry examined takes a memory read (S_RD), then a compare
// and move (S_CMP); the walk ends with the write of the new record (S_WRNEW) and S_DONE.
// A read passes S_RD and S_DONE; a full or out-of-range item goes straight to S_DONE.
// One item is in flight at a time; the result sits in an output register until taken.
// Depends on sti_pkg and sti_ram.
module sorted_table_insert import sti_pkg::*; #(
    parameter int DEPTH     = STI_DEPTH,
    parameter int KEY_CHARS = STI_KEY_CHARS
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic               i_mode,
    input  logic        [63:0] i_title_key,
    input  logic        [63:0] i_publisher_text,
    input  logic signed [31:0] i_price_value,
    input  logic        [3:0]  i_read_index,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic        [1:0]  o_status,
    output logic        [4:0]  o_entry_count,
    output logic        [3:0]  o_slot,
    output logic        [63:0] o_out_title,
    output logic        [63:0] o_out_publisher,
    output logic signed [31:0] o_out_price
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [63:0] KeyMask = ~64'd0 << (64 - 8 * KEY_CHARS);

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_RD    = 5'b00010,
        S_CMP   = 5'b00100,
        S_WRNEW = 5'b01000,
        S_DONE  = 5'b10000
    } t_state;

    t_state  r_state, n_state;
    logic [CW-1:0] r_count, n_count;
    logic [AW-1:0] r_idx, n_idx;
    logic [AW-1:0] r_pos, n_pos;
    logic          r_mode, n_mode;
    t_status       r_status, n_status;
    logic [3:0]    r_slot, n_slot;
    t_record       r_new, n_new;
    logic          r_out_valid, n_out_valid;
    t_status       r_o_status, n_o_status;
    logic [4:0]    r_o_count, n_o_count;
    logic [3:0]    r_o_slot, n_o_slot;
    t_record       r_o_rec, n_o_rec;

    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    t_record       ram_wdata;
    t_record       ram_rdata;

    sti_ram #(
        .WIDTH ($bits(t_record)),
        .DEPTH (DEPTH)
    ) u_sti_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (r_idx),
        .o_rdata (ram_rdata)
    );

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_idx       = r_idx;
        n_pos       = r_pos;
        n_mode      = r_mode;
        n_status    = r_status;
        n_slot      = r_slot;
        n_new       = r_new;
        n_out_valid = r_out_valid;
        n_o_status  = r_o_status;
        n_o_count   = r_o_count;
        n_o_slot    = r_o_slot;
        n_o_rec     = r_o_rec;
        ram_we      = 1'b0;
        ram_waddr   = r_pos;
        ram_wdata   = r_new;

        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_mode          = i_mode;
                    n_new.key       = i_title_key & KeyMask;
                    n_new.publisher = i_publisher_text;
                    n_new.price     = i_price_value;
                    n_status        = ST_OK;
                    if (!i_mode) begin
                        if (r_count == CW'(DEPTH)) begin
                            n_status = ST_FULL;
                            n_slot   = '0;
                            n_state  = S_DONE;
                        end else if (r_count == '0) begin
                            n_pos   = '0;
                            n_state = S_WRNEW;
                        end else begin
                            // start the walk at the top stored entry
                            n_idx   = AW'(r_count - CW'(1));
                            n_state = S_RD;
                        end
                    end else begin
                        n_slot = i_read_index;
                        if (32'(i_read_index) >= 32'(r_count)) begin
                            n_status = ST_RANGE;
                            n_state  = S_DONE;
                        end else begin
                            n_idx   = AW'(i_read_index);
                            n_state = S_RD;
                        end
                    end
                end
            end
            S_RD: begin
                n_state = r_mode ? S_DONE : S_CMP;
            end
            S_CMP: begin
                if (ram_rdata.key > r_new.key) begin
                    // move this entry up one place and keep walking down
                    ram_we    = 1'b1;
                    ram_waddr = r_idx + AW'(1);
                    ram_wdata = ram_rdata;
                    if (r_idx == '0) begin
                        n_pos   = '0;
                        n_state = S_WRNEW;
                    end else begin
                        n_idx   = r_idx - AW'(1);
                        n_state = S_RD;
                    end
                end else begin
                    n_pos   = r_idx + AW'(1);
                    n_state = S_WRNEW;
                end
            end
            S_WRNEW: begin
                ram_we    = 1'b1;
                ram_waddr = r_pos;
                ram_wdata = r_new;
                n_count   = r_count + CW'(1);
                n_slot    = 4'(r_pos);
                n_state   = S_DONE;
            end
            S_DONE: begin
                // hold until the output register is free
                if (!r_out_valid || i_out_ready) begin
                    n_out_valid = 1'b1;
                    n_o_status  = r_status;
                    n_o_count   = 5'(r_count);
                    n_o_slot    = r_slot;
                    if (r_mode && r_status == ST_OK) begin
                        n_o_rec = ram_rdata;
                    end else begin
                        n_o_rec = '0;
                    end
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx      <= n_idx;
        r_pos      <= n_pos;
        r_mode     <= n_mode;
        r_status   <= n_status;
        r_slot     <= n_slot;
        r_new      <= n_new;
        r_o_status <= n_o_status;
        r_o_count  <= n_o_count;
        r_o_slot   <= n_o_slot;
        r_o_rec    <= n_o_rec;
    end

    assign o_in_ready      = (r_state == S_IDLE);
    assign o_out_valid     = r_out_valid;
    assign o_status        = r_o_status;
    assign o_entry_count   = r_o_count;
    assign o_slot          = r_o_slot;
    assign o_out_title     = r_o_rec.key;
    assign o_out_publisher = r_o_rec.publisher;
    assign o_out_price     = r_o_rec.price;

endmodule

// ===== src/sti_checker.sv =====
// Port-level checks for the sorted record table, bound to sorted_table_insert.
// Depends on sti_pkg.
module sti_port_props import sti_pkg::*; #(
    parameter int DEPTH = STI_DEPTH
) (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               o_out_valid,
    input logic               i_out_ready,
    input logic        [1:0]  o_status,
    input logic        [4:0]  o_entry_count,
    input logic        [3:0]  o_slot,
    input logic        [63:0] o_out_title,
    input logic        [63:0] o_out_publisher,
    input logic signed [31:0] o_out_price
);

    // a stalled result transaction holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=>
            o_out_valid && $stable(o_status) && $stable(o_slot) && $stable(o_entry_count))
        else $error("result changed while stalled");

    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_status != ST_OK |->
            o_out_title == '0 && o_out_publisher == '0 && o_out_price == '0)
        else $error("payload not cleared on error status");

    a_full_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_status == ST_FULL |-> o_entry_count == 5'(DEPTH) && o_slot == '0)
        else $error("full status with count below depth");

    a_range_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_status == ST_RANGE |-> {1'b0, o_slot} >= o_entry_count)
        else $error("range status with index inside table");

endmodule

bind sorted_table_insert sti_port_props #(
    .DEPTH (DEPTH)
) u_sti_port_props (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_out_valid     (o_out_valid),
    .i_out_ready     (i_out_ready),
    .o_status        (o_status),
    .o_entry_count   (o_entry_count),
    .o_slot          (o_slot),
    .o_out_title     (o_out_title),
    .o_out_publisher (o_out_publisher),
    .o_out_price     (o_out_price)
);

// ===== dv/sti_tb_pkg.sv =====
`timescale 1ns / 1ps
// Testbench-side types for the sorted record table: item mode codes and the result record.
// Depends on sti_pkg; used by the checker and the testbench top.
package sti_tb_pkg;
    import sti_pkg::*;

    typedef enum logic {
        MODE_INSERT = 1'b0,
        MODE_READ   = 1'b1
    } t_mode;

    typedef struct {
        t_status            status;
        logic        [4:0]  entry_count;
        logic        [3:0]  slot;
        logic        [63:0] title;
        logic        [63:0] publisher;
        logic signed [31:0] price;
    } t_table_result;

endpackage

// ===== dv/sti_checker.sv =====
`timescale 1ns / 1ps
// Checker for sorted_table_insert: keeps its own copy of the ordered table, predicts each
// result from accepted transactions and compares delivered results field by field.
// Depends on sti_pkg and sti_tb_pkg.
module sti_checker import sti_pkg::*; import sti_tb_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic               i_in_ready,
    input  logic               i_mode,
    input  logic        [63:0] i_title_key,
    input  logic        [63:0] i_publisher_text,
    input  logic signed [31:0] i_price_value,
    input  logic        [3:0]  i_read_index,
    input  logic               i_out_valid,
    input  logic               i_out_ready,
    input  logic        [1:0]  i_status,
    input  logic        [4:0]  i_entry_count,
    input  logic        [3:0]  i_slot,
    input  logic        [63:0] i_out_title,
    input  logic        [63:0] i_out_publisher,
    input  logic signed [31:0] i_out_price,
    output int                 o_mismatches,
    output int                 o_results_due
);

    localparam logic [63:0] KEY_MASK = ~64'd0 << (64 - 8 * STI_KEY_CHARS);

    logic        [63:0] title_mem     [STI_DEPTH];
    logic        [63:0] publisher_mem [STI_DEPTH];
    logic signed [31:0] price_mem     [STI_DEPTH];
    int                 table_fill;
    t_table_result      results_due_q [$];

    initial begin
        o_mismatches  = 0;
        o_results_due = 0;
        table_fill    = 0;
    end

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("%0t sti_checker: %s got %h want %h", $time, what, got, want);
        o_mismatches++;
    endtask

    // Apply one item to the shadow table and return what the block should answer.
    task automatic place_or_fetch(input t_mode mode, input logic [63:0] key_in,
                                  input logic [63:0] pub, input logic signed [31:0] price,
                                  input logic [3:0] idx, output t_table_result res);
        logic [63:0] key;
        int          pos;
        key             = key_in & KEY_MASK;
        res.status      = ST_OK;
        res.entry_count = 5'(table_fill);
        res.slot        = idx;
        res.title       = '0;
        res.publisher   = '0;
        res.price       = '0;
        if (mode == MODE_INSERT) begin
            if (table_fill >= STI_DEPTH) begin
                res.status = ST_FULL;
                res.slot   = '0;
                return;
            end
            pos = table_fill;
            for (int j = 0; j < table_fill; j++) begin
                if (title_mem[j] > key) begin
                    pos = j;
                    break;
                end
            end
            for (int j = table_fill; j > pos; j--) begin
                title_mem[j]     = title_mem[j - 1];
                publisher_mem[j] = publisher_mem[j - 1];
                price_mem[j]     = price_mem[j - 1];
            end
            title_mem[pos]     = key;
            publisher_mem[pos] = pub;
            price_mem[pos]     = price;
            table_fill++;
            res.entry_count = 5'(table_fill);
            res.slot        = 4'(pos);
        end else if (int'(idx) >= table_fill) begin
            res.status = ST_RANGE;
        end else begin
            res.title     = title_mem[idx];
            res.publisher = publisher_mem[idx];
            res.price     = price_mem[idx];
        end
    endtask

    always @(posedge i_clk) begin
        t_table_result want;
        if (i_rst_n) begin
            // Drain side first: a result leaving now always belongs to an older transaction.
            if (i_out_valid && i_out_ready) begin
                if (results_due_q.size() == 0) begin
                    report_mismatch("unexpected result, status", 64'(i_status), '0);
                end else begin
                    want = results_due_q.pop_front();
                    if (i_status !== want.status)
                        report_mismatch("status", 64'(i_status), 64'(want.status));
                    if (i_entry_count !== want.entry_count)
                        report_mismatch("entry_count", 64'(i_entry_count),
                                        64'(want.entry_count));
                    if (i_slot !== want.slot)
                        report_mismatch("slot", 64'(i_slot), 64'(want.slot));
                    if (i_out_title !== want.title)
                        report_mismatch("out_title", i_out_title, want.title);
                    if (i_out_publisher !== want.publisher)
                        report_mismatch("out_publisher", i_out_publisher, want.publisher);
                    if (i_out_price !== want.price)
                        report_mismatch("out_price", 64'(i_out_price), 64'(want.price));
                end
            end
            if (i_in_valid && i_in_ready) begin
                place_or_fetch(t_mode'(i_mode), i_title_key, i_publisher_text,
                               i_price_value, i_read_index, want);
                results_due_q.push_back(want);
            end
            o_results_due = results_due_q.size();
        end
    end

endmodule

// ===== dv/tb_sorted_table_insert.sv =====
`timescale 1ns / 1ps
// Testbench top for sorted_table_insert: clock, reset, directed and random item traffic,
// random output back-pressure and the final verdict. Depends on sti_pkg, sti_tb_pkg and
// sti_checker.
module tb_sorted_table_insert;
    import sti_pkg::*;
    import sti_tb_pkg::*;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_in_valid;
    logic               o_in_ready;
    logic               i_mode;
    logic        [63:0] i_title_key;
    logic        [63:0] i_publisher_text;
    logic signed [31:0] i_price_value;
    logic        [3:0]  i_read_index;
    logic               o_out_valid;
    logic               i_out_ready;
    logic        [1:0]  o_status;
    logic        [4:0]  o_entry_count;
    logic        [3:0]  o_slot;
    logic        [63:0] o_out_title;
    logic        [63:0] o_out_publisher;
    logic signed [31:0] o_out_price;

    int          mismatches;
    int          results_due;
    int          items_sent;
    logic [63:0] used_keys [$];

    localparam int CALM_FIRST = 1000;
    localparam int CALM_LAST  = 1300;

    sorted_table_insert dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_mode           (i_mode),
        .i_title_key      (i_title_key),
        .i_publisher_text (i_publisher_text),
        .i_price_value    (i_price_value),
        .i_read_index     (i_read_index),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_status         (o_status),
        .o_entry_count    (o_entry_count),
        .o_slot           (o_slot),
        .o_out_title      (o_out_title),
        .o_out_publisher  (o_out_publisher),
        .o_out_price      (o_out_price)
    );

    sti_checker u_sti_checker (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .i_in_ready       (o_in_ready),
        .i_mode           (i_mode),
        .i_title_key      (i_title_key),
        .i_publisher_text (i_publisher_text),
        .i_price_value    (i_price_value),
        .i_read_index     (i_read_index),
        .i_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .i_status         (o_status),
        .i_entry_count    (o_entry_count),
        .i_slot           (o_slot),
        .i_out_title      (o_out_title),
        .i_out_publisher  (o_out_publisher),
        .i_out_price      (o_out_price),
        .o_mismatches     (mismatches),
        .o_results_due    (results_due)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #6ms;
        $display("tb_sorted_table_insert: errors");
        $finish;
    end

    // Idle at random before the transaction, then hold it until the block takes it.
    task automatic offer_item(input t_mode mode, input logic [63:0] key,
                              input logic [63:0] pub, input logic signed [31:0] price,
                              input logic [3:0] idx);
        while (!(items_sent >= CALM_FIRST && items_sent < CALM_LAST)
               && $urandom_range(99) < 29) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid       <= 1'b1;
        i_mode           <= mode;
        i_title_key      <= key;
        i_publisher_text <= pub;
        i_price_value    <= price;
        i_read_index     <= idx;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        if (mode == MODE_INSERT) used_keys.push_back(key);
        items_sent++;
    endtask

    // Result side: random stalls, one long hold-off and a calm stretch.
    initial begin
        int hold_left;
        bit hold_done;
        hold_left   = 0;
        hold_done   = 1'b0;
        i_out_ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (!hold_done && items_sent >= 300) begin
                hold_done = 1'b1;
                hold_left = 250;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_out_ready <= 1'b0;
            end else if (items_sent >= CALM_FIRST && items_sent < CALM_LAST) begin
                i_out_ready <= 1'b1;
            end else begin
                i_out_ready <= ($urandom_range(99) >= 29);
            end
        end
    end

    initial begin
        logic [63:0] key;
        t_mode       mode;
        int          pick;
        items_sent       = 0;
        i_rst_n          <= 1'b0;
        i_in_valid       <= 1'b0;
        i_mode           <= MODE_INSERT;
        i_title_key      <= '0;
        i_publisher_text <= '0;
        i_price_value    <= '0;
        i_read_index     <= '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Empty table: both ends of the index range are out of range.
        offer_item(MODE_READ, '0, '0, '0, 4'd0);
        offer_item(MODE_READ, '1, '1, '1, 4'd15);
        offer_item(MODE_INSERT, 64'h4D49_4444_4C45_0000, '1, 32'sh7FFF_FFFF, 4'd0);
        offer_item(MODE_INSERT, '1, 64'h5055_4231_0000_0000, 32'sh8000_0000, 4'd15);
        offer_item(MODE_INSERT, '0, '0, '0, 4'd0);
        // Equal keys must keep arrival order.
        offer_item(MODE_INSERT, 64'h4D49_4444_4C45_0000, 64'h5345_434F_4E44_0000, -32'sd1,
                   4'd0);
        // Zero byte ahead of a nonzero one still compares as a whole number.
        offer_item(MODE_INSERT, 64'h0041_0000_0000_0000, 64'h5A45_524F_0000_0000, 32'sd17,
                   4'd0);
        offer_item(MODE_INSERT, 64'h4100_0000_0000_0001, 64'h0000_0000_0000_0001, 32'sd5,
                   4'd0);
        offer_item(MODE_INSERT, '1, 64'hAAAA_5555_AAAA_5555, 32'sd3, 4'd0);
        offer_item(MODE_INSERT, '0, 64'h5555_AAAA_5555_AAAA, -32'sd42, 4'd0);
        offer_item(MODE_INSERT, 64'h4100_0000_0000_0000, 64'h1234_5678_9ABC_DEF0, 32'sd9,
                   4'd0);
        offer_item(MODE_INSERT, 64'h8000_0000_0000_0000, 64'h0F0F_F0F0_0F0F_F0F0, 32'sd1,
                   4'd0);
        for (int i = 0; i <= 10; i++)
            offer_item(MODE_READ, '0, '0, '0, 4'(i));

        for (int n = 0; n < 1950; n++) begin
            mode = ($urandom_range(99) < 30) ? MODE_INSERT : MODE_READ;
            pick = $urandom_range(3);
            if (pick == 0 && used_keys.size() != 0)
                key = used_keys[$urandom_range(used_keys.size() - 1)];
            else if (pick == 1)
                key = {8'h00, 24'($urandom), $urandom};
            else if (pick == 2)
                key = {8'(8'h41 + $urandom_range(25)), 24'($urandom), $urandom};
            else
                key = {$urandom, $urandom};
            offer_item(mode, key, {$urandom, $urandom}, $urandom, 4'($urandom_range(15)));
        end
        i_in_valid <= 1'b0;

        // let the checker log the last transaction before polling the count
        @(posedge i_clk);
        while (results_due != 0) @(posedge i_clk);
        repeat (50) @(posedge i_clk);
        if (mismatches == 0)
            $display("tb_sorted_table_insert: clean");
        else
            $display("tb_sorted_table_insert: errors");
        $finish;
    end

endmodule
